// ----- design/assert_macros.svh -----
// Assertion helpers, sampled on clk and quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent now, consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/owsm_pkg.sv -----
`default_nettype none
package owsm_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int SPEED_FRAC_BITS = 8;
  localparam int ANGLE_FRAC      = 16;
  localparam int SCALE_SHIFT     = COORD_WIDTH - 1 + ANGLE_FRAC - SPEED_FRAC_BITS;

  localparam int MAX_W   = 8;
  localparam int ROOT_W  = 16;
  localparam int RAD_W   = 32;
  localparam int MAG_W   = 17;
  localparam int SPEED_W = 18;
  localparam int DIR_W   = 2;
  localparam int ANGLE_W = 17;

  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 17;
  localparam int MUL_W   = MUL_A_W + MUL_B_W;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam int CX_W         = 35;
  localparam int Z_W          = 19;

  localparam logic [ANGLE_W-1:0] ANGLE_ONE     = 17'd65536;
  localparam logic [MAG_W-1:0]   SPEED_MAG_MAX = 17'd131071;
  localparam logic [ROOT_W-1:0]  ROOT_MAX      = 16'd46341;
  localparam logic [MAX_W-1:0]   PWM_FULL_RST  = 8'd100;

  localparam logic [DIR_W-1:0] DIR_ZERO = 2'b00;
  localparam logic [DIR_W-1:0] DIR_POS  = 2'b01;
  localparam logic [DIR_W-1:0] DIR_NEG  = 2'b11;

  // wheel one in element 0
  typedef logic [3:0][DIR_W-1:0] dirs_t;

  localparam dirs_t DIRS_FWD   = {DIR_NEG, DIR_POS, DIR_NEG, DIR_POS};
  localparam dirs_t DIRS_RIGHT = {DIR_NEG, DIR_NEG, DIR_POS, DIR_POS};
  localparam dirs_t DIRS_BACK  = {DIR_POS, DIR_NEG, DIR_POS, DIR_NEG};
  localparam dirs_t DIRS_LEFT  = {DIR_POS, DIR_POS, DIR_NEG, DIR_NEG};
  localparam dirs_t DIRS_ZERO  = {DIR_ZERO, DIR_ZERO, DIR_ZERO, DIR_ZERO};
  localparam dirs_t DIRS_SPIN_L = {DIR_POS, DIR_POS, DIR_POS, DIR_POS};
  localparam dirs_t DIRS_SPIN_R = {DIR_NEG, DIR_NEG, DIR_NEG, DIR_NEG};

  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;

  // atan(2^-i) / 45 deg, 16 fraction bits
  function automatic logic [ANGLE_W-1:0] atan_step(input logic [STEP_W-1:0] i);
    logic [ANGLE_W-1:0] v;
    unique case (i)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd38688;
      4'd2:  v = 17'd20442;
      4'd3:  v = 17'd10377;
      4'd4:  v = 17'd5208;
      4'd5:  v = 17'd2607;
      4'd6:  v = 17'd1304;
      4'd7:  v = 17'd652;
      4'd8:  v = 17'd326;
      4'd9:  v = 17'd163;
      4'd10: v = 17'd81;
      4'd11: v = 17'd41;
      4'd12: v = 17'd20;
      4'd13: v = 17'd10;
      4'd14: v = 17'd5;
      4'd15: v = 17'd3;
    endcase
    return v;
  endfunction

  // round half up to SPEED_FRAC_BITS, saturate the magnitude
  function automatic logic [MAG_W-1:0] scale_round(input logic [MUL_W-1:0] p);
    logic [MUL_W:0]             s;
    logic [MUL_W-SCALE_SHIFT:0] q;
    s = {1'b0, p} + ((MUL_W+1)'(1) << (SCALE_SHIFT - 1));
    q = s[MUL_W:SCALE_SHIFT];
    if (q > (MUL_W-SCALE_SHIFT+1)'(SPEED_MAG_MAX)) begin
      return SPEED_MAG_MAX;
    end
    return q[MAG_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- design/owsm_mul.sv -----
`default_nettype none
module owsm_mul import owsm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               go,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output logic      [MUL_W-1:0]   prod
);

  logic [MUL_W-1:0] prod_r;

  // product holds until the next issue
  always_ff @(posedge clk) begin
    if (go) begin
      prod_r <= MUL_W'(a) * MUL_W'(b);
    end
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

// ----- design/owsm_sqrt.sv -----
`default_nettype none
module owsm_sqrt import owsm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [RAD_W-1:0]  radicand,
  output logic      [ROOT_W-1:0] root,
  output iter_stat_t             stat
);

  localparam int REM_W = ROOT_W + 2;
  localparam int ACC_W = REM_W + 2;

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] q_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r, done_r;

  logic [ACC_W-1:0] acc, trial, diff;
  logic             take;

  // one root bit per cycle, two radicand bits in
  always_comb begin
    acc   = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial = {2'b00, q_r, 2'b01};
    diff  = acc - trial;
    take  = (acc >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == STEP_W'(ROOT_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r <= radicand;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r <= take ? diff[REM_W-1:0] : acc[REM_W-1:0];
      q_r   <= {q_r[ROOT_W-2:0], take};
    end
  end

  assign root = q_r;
  assign stat = '{busy: busy_r, done: done_r};

endmodule
`default_nettype wire

// ----- design/owsm_cordic.sv -----
`default_nettype none
module owsm_cordic import owsm_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [COORD_WIDTH-1:0] major,
  input  wire logic [COORD_WIDTH-1:0] minor,
  output logic      [ANGLE_W-1:0]     angle,
  output iter_stat_t                  stat
);

  logic signed [CX_W-1:0] cx_r, cy_r;
  logic signed [Z_W-1:0]  z_r;
  logic [STEP_W-1:0]      step_r;
  logic                   busy_r, done_r;

  logic signed [CX_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  dz;

  // arithmetic shift gives the floor
  always_comb begin
    dx = cy_r >>> step_r;
    dy = cx_r >>> step_r;
    dz = $signed({2'b00, atan_step(step_r)});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cx_r <= $signed({(CX_W-COORD_WIDTH-ANGLE_FRAC)'(0), major, ANGLE_FRAC'(0)});
      cy_r <= $signed({(CX_W-COORD_WIDTH-ANGLE_FRAC)'(0), minor, ANGLE_FRAC'(0)});
      z_r  <= '0;
    end else if (busy_r) begin
      if (!cy_r[CX_W-1]) begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        z_r  <= z_r + dz;
      end else begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        z_r  <= z_r - dz;
      end
    end
  end

  // clamp to [0, one]
  always_comb begin
    if (z_r[Z_W-1]) begin
      angle = '0;
    end else if (z_r > $signed({2'b00, ANGLE_ONE})) begin
      angle = ANGLE_ONE;
    end else begin
      angle = z_r[ANGLE_W-1:0];
    end
  end

  assign stat = '{busy: busy_r, done: done_r};

endmodule
`default_nettype wire

// ----- design/omni_wheel_speed_mixer.sv -----
// Omni-wheel speed mixer. One word on in_ carries a joystick vector
// (move_x, move_y, Q1.15) and the spin flags; one word on out_ returns four
// signed wheel speeds (8 fraction bits) and four directions. Each word
// goes from acceptance to out_tvalid through two squaring passes on the
// shared multiplier, a 16-step square root run alongside a 16-step angle
// CORDIC, then three more multiplier passes for the speed scaling.
// in_tready rises in the same cycle as out_tvalid; a new word is taken
// only after the last has finished. A finished word waits in the output
// register while the next word is taken in; the next word then holds in
// its last step until out_tready frees that register. The full-scale PWM
// speed is written through cfg_we / cfg_wdata and resets to 100.
`default_nettype none
module omni_wheel_speed_mixer import owsm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,   // full-scale PWM speed
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // move_x [15:0], move_y [31:16]
  input  wire logic [1:0]  in_tuser,    // spin_left [0], spin_right [1]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata    // speed_one..speed_four [71:0], 18b each,
                                        // dir_one..dir_four [79:72], 2b each
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQX  = 3'd1;
  localparam logic [2:0] S_SQY  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_ROOT = 3'd4;
  localparam logic [2:0] S_FULL = 3'd5;
  localparam logic [2:0] S_RED  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state_r, state_nxt;

  logic [MAX_W-1:0]       pwm_full_r;
  logic [COORD_WIDTH-1:0] ax_r, ay_r, major_r, minor_r;
  logic                   sl_r, sr_r, red14_r, red23_r;
  dirs_t                  dirs_r, dirs_nxt;
  logic [RAD_W-1:0]       sq_r;
  logic [MUL_A_W-1:0]     mr_r;
  logic [MAG_W-1:0]       full_r;

  logic                            out_valid_r;
  logic [3:0][SPEED_W-1:0]         out_speed_r;
  dirs_t                           out_dirs_r;

  // input decode
  logic signed [COORD_WIDTH-1:0] mx, my;
  logic [COORD_WIDTH-1:0]        ax, ay;
  logic                          xp, xn, yp, yn, x_gt, red14, red23;
  logic                          in_fire, out_fire, fin_load;

  // shared multiplier
  logic               mul_go;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_W-1:0]   prod;

  logic [ROOT_W-1:0]  sq_root;
  logic [ANGLE_W-1:0] angle;
  iter_stat_t         sq_stat, cr_stat;
  logic               units_done;

  logic [MAG_W-1:0]   red_mag, spin_mag;
  logic [3:0][MAG_W-1:0]   mag;
  logic [3:0][SPEED_W-1:0] speed;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;
  assign fin_load  = (state_r == S_FIN) && (!out_valid_r || out_tready);
  assign units_done = sq_stat.done && cr_stat.done;

  always_comb begin
    mx   = $signed(in_tdata[15:0]);
    my   = $signed(in_tdata[31:16]);
    ax   = mx[COORD_WIDTH-1] ? COORD_WIDTH'(-mx) : COORD_WIDTH'(mx);
    ay   = my[COORD_WIDTH-1] ? COORD_WIDTH'(-my) : COORD_WIDTH'(my);
    xn   = mx[COORD_WIDTH-1];
    yn   = my[COORD_WIDTH-1];
    xp   = !xn && (mx != '0);
    yp   = !yn && (my != '0);
    x_gt = (ax > ay);
    red14 = 1'b0;
    red23 = 1'b0;
    dirs_nxt = dirs_r;
    if (xp && yp) begin
      dirs_nxt = (ax < ay) ? DIRS_FWD : DIRS_RIGHT;
      red23 = 1'b1;
    end else if (xp && yn) begin
      dirs_nxt = x_gt ? DIRS_RIGHT : DIRS_BACK;
      red14 = 1'b1;
    end else if (xn && yn) begin
      dirs_nxt = x_gt ? DIRS_LEFT : DIRS_BACK;
      red23 = 1'b1;
    end else if (xn && yp) begin
      dirs_nxt = x_gt ? DIRS_LEFT : DIRS_FWD;
      red14 = 1'b1;
    end else if (yp) begin
      dirs_nxt = DIRS_FWD;
    end else if (yn) begin
      dirs_nxt = DIRS_BACK;
    end else if (xp) begin
      dirs_nxt = DIRS_RIGHT;
    end else if (xn) begin
      dirs_nxt = DIRS_LEFT;
    end
    // a single spin flag overrides the move
    if (in_tuser[0] && !in_tuser[1]) begin
      dirs_nxt = DIRS_SPIN_L;
    end else if (in_tuser[1] && !in_tuser[0]) begin
      dirs_nxt = DIRS_SPIN_R;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_SQX;
      S_SQX:  state_nxt = S_SQY;
      S_SQY:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_ROOT;
      S_ROOT: if (units_done) state_nxt = S_FULL;
      S_FULL: state_nxt = S_RED;
      S_RED:  state_nxt = S_FIN;
      S_FIN:  if (fin_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mul_go = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      S_SQX: begin
        mul_go = 1'b1;
        mul_a  = MUL_A_W'(ax_r);
        mul_b  = MUL_B_W'(ax_r);
      end
      S_SQY: begin
        mul_go = 1'b1;
        mul_a  = MUL_A_W'(ay_r);
        mul_b  = MUL_B_W'(ay_r);
      end
      S_ROOT: begin
        mul_go = units_done;
        mul_a  = MUL_A_W'(pwm_full_r);
        mul_b  = MUL_B_W'(sq_root);
      end
      S_FULL: begin
        mul_go = 1'b1;
        mul_a  = prod[MUL_A_W-1:0];
        mul_b  = ANGLE_ONE;
      end
      S_RED: begin
        mul_go = 1'b1;
        mul_a  = mr_r;
        mul_b  = ANGLE_ONE - angle;
      end
      default: begin
        mul_go = 1'b0;
      end
    endcase
  end

  owsm_mul u_mul (
    .clk  (clk),
    .go   (mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  owsm_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_SUM),
    .radicand (sq_r + prod[RAD_W-1:0]),
    .root     (sq_root),
    .stat     (sq_stat)
  );

  owsm_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_SUM),
    .major (major_r),
    .minor (minor_r),
    .angle (angle),
    .stat  (cr_stat)
  );

  always_comb begin
    red_mag  = scale_round(prod);
    spin_mag = MAG_W'({pwm_full_r, SPEED_FRAC_BITS'(0)});
    for (int k = 0; k < 4; k++) begin
      if (sl_r && sr_r) begin
        mag[k] = '0;
      end else if (sl_r || sr_r) begin
        mag[k] = spin_mag;
      end else if ((red14_r && (k == 0 || k == 3)) || (red23_r && (k == 1 || k == 2))) begin
        mag[k] = red_mag;
      end else begin
        mag[k] = full_r;
      end
      case (dirs_r[k])
        DIR_POS: speed[k] = {1'b0, mag[k]};
        DIR_NEG: speed[k] = SPEED_W'(-{1'b0, mag[k]});
        default: speed[k] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pwm_full_r  <= PWM_FULL_RST;
      dirs_r      <= DIRS_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        pwm_full_r <= cfg_wdata;
      end
      if (in_fire) begin
        dirs_r <= dirs_nxt;
      end
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ax_r    <= ax;
      ay_r    <= ay;
      major_r <= (ax >= ay) ? ax : ay;
      minor_r <= (ax >= ay) ? ay : ax;
      sl_r    <= in_tuser[0];
      sr_r    <= in_tuser[1];
      red14_r <= red14;
      red23_r <= red23;
    end
    if (state_r == S_SQY) begin
      sq_r <= prod[RAD_W-1:0];
    end
    if (state_r == S_FULL) begin
      mr_r <= prod[MUL_A_W-1:0];
    end
    if (state_r == S_RED) begin
      full_r <= scale_round(prod);
    end
    if (fin_load) begin
      out_speed_r <= speed;
      out_dirs_r  <= dirs_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_dirs_r[3], out_dirs_r[2], out_dirs_r[1], out_dirs_r[0],
                       out_speed_r[3], out_speed_r[2], out_speed_r[1], out_speed_r[0]};

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_units_idle, (state_r == S_IDLE) |-> (!sq_stat.busy && !cr_stat.busy), "iterative unit busy while mixer idle")
  `ASSERT_NEXT(a_units_start, (state_r == S_SUM), (sq_stat.busy && cr_stat.busy), "units did not start")
  `ASSERT_ALWAYS(a_root_range, sq_stat.done |-> (sq_root <= ROOT_MAX), "vector length out of range")
  `ASSERT_ALWAYS(a_zero_dir, (out_valid_r && (out_dirs_r[0] == DIR_ZERO)) |-> (out_speed_r[0] == '0), "speed without direction")

endmodule
`default_nettype wire
